### src/tpi_pkg.sv
package tpi_pkg;

    localparam int FracBits  = 16;
    localparam int ProgW     = FracBits + 1;
    localparam int CoordW    = 15;
    localparam int DiffW     = 16;
    localparam int SqW       = 32;
    localparam int LenW      = 16;
    localparam int SpeedW    = 16;
    localparam int TimeW     = 16;
    localparam int NumW      = SpeedW + TimeW + FracBits;
    localparam int DenW      = LenW + 16;
    localparam int CntW      = 6;
    localparam int RegIdxW   = 3;
    localparam int CfgW      = 16;
    localparam int SpeedReset = 640;

    localparam logic [RegIdxW-1:0] RegSpeed  = 3'd0;
    localparam logic [RegIdxW-1:0] RegYaw0   = 3'd1;
    localparam logic [RegIdxW-1:0] RegPitch0 = 3'd2;
    localparam logic [RegIdxW-1:0] RegYaw1   = 3'd3;
    localparam logic [RegIdxW-1:0] RegPitch1 = 3'd4;
    localparam logic [RegIdxW-1:0] RegYaw2   = 3'd5;
    localparam logic [RegIdxW-1:0] RegPitch2 = 3'd6;

    typedef struct packed {
        logic load;
        logic sq_step;
        logic sqrt_init;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic advance;
        logic interp_a;
        logic interp_b;
        logic out_load;
    } tpi_cmd_t;

    typedef struct packed {
        logic len_zero;
        logic done_cnt;
    } tpi_status_t;

endpackage

### src/tpi_ctrl.sv
module tpi_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic                out_busy,
    input  tpi_pkg::tpi_status_t status,
    output logic                in_ready,
    output tpi_pkg::tpi_cmd_t   cmd
);

    localparam logic [3:0] StIdle  = 4'd0;
    localparam logic [3:0] StSq    = 4'd1;
    localparam logic [3:0] StSqrtI = 4'd2;
    localparam logic [3:0] StSqrt  = 4'd3;
    localparam logic [3:0] StDivI  = 4'd4;
    localparam logic [3:0] StDiv   = 4'd5;
    localparam logic [3:0] StAdv   = 4'd6;
    localparam logic [3:0] StIntA  = 4'd7;
    localparam logic [3:0] StIntB  = 4'd8;
    localparam logic [3:0] StOut   = 4'd9;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StIdle;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            StIdle:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = StSq;
                end
            end
            StSq:
            begin
                cmd.sq_step = 1'b1;
                state_next = StSqrtI;
            end
            StSqrtI:
            begin
                cmd.sqrt_init = 1'b1;
                state_next = StSqrt;
            end
            StSqrt:
            begin
                cmd.sqrt_step = 1'b1;
                if (status.done_cnt)
                begin
                    state_next = StDivI;
                end
            end
            StDivI:
            begin
                if (status.len_zero)
                begin
                    state_next = StAdv;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next = StDiv;
                end
            end
            StDiv:
            begin
                cmd.div_step = 1'b1;
                if (status.done_cnt)
                begin
                    state_next = StAdv;
                end
            end
            StAdv:
            begin
                cmd.advance = 1'b1;
                state_next = StIntA;
            end
            StIntA:
            begin
                cmd.interp_a = 1'b1;
                state_next = StIntB;
            end
            StIntB:
            begin
                cmd.interp_b = 1'b1;
                state_next = StOut;
            end
            StOut:
            begin
                if (!out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next = StIdle;
                end
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

endmodule

### src/tpi_datapath.sv
module tpi_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  tpi_pkg::tpi_cmd_t                   cmd,
    input  logic                                cfg_we,
    input  logic [tpi_pkg::RegIdxW-1:0]         cfg_addr,
    input  logic [tpi_pkg::CfgW-1:0]            cfg_data,
    input  logic [tpi_pkg::TimeW-1:0]           time_in,
    input  logic                                out_ready,
    output tpi_pkg::tpi_status_t                status,
    output logic                                out_busy,
    output logic                                out_valid,
    output logic [39:0]                         out_data
);

    localparam int CW = tpi_pkg::CoordW;
    localparam int DW = tpi_pkg::DiffW;
    localparam int PW = tpi_pkg::ProgW;
    localparam int NW = tpi_pkg::NumW;
    localparam int QW = tpi_pkg::DenW;
    localparam int MW = tpi_pkg::SpeedW + tpi_pkg::TimeW;

    logic [tpi_pkg::SpeedW-1:0] speed_reg;
    logic signed [CW-1:0]       yaw_reg [3];
    logic signed [CW-1:0]       pitch_reg [3];
    logic [1:0]                 sv_reg;
    logic [PW-1:0]              prog_reg;
    logic [tpi_pkg::TimeW-1:0]  time_reg;
    logic [tpi_pkg::CntW-1:0]   cnt_reg;
    logic signed [DW-1:0]       dy_reg, dp_reg;
    logic [tpi_pkg::SqW-1:0]    sq_reg;
    logic [tpi_pkg::SqW+1:0]    rem_reg;
    logic [tpi_pkg::LenW-1:0]   root_reg;
    logic [NW-1:0]              quo_reg;
    logic [QW:0]                drem_reg;
    logic [QW-1:0]              den_reg;
    logic                       sw_reg, deg_reg;
    logic signed [DW+PW:0]      py_reg, pp_reg;
    logic signed [CW-1:0]       ty_reg, tp_reg;
    logic                       ovalid_reg;
    logic [39:0]                odata_reg;

    logic [1:0] s_cur, e_cur, e_nxt;
    logic signed [DW-1:0] dy_c, dp_c;
    logic [tpi_pkg::SqW+1:0] trial;
    logic [QW:0] dtrial;
    logic [NW:0] sum_w;
    logic       fin;
    logic signed [DW+PW:0] fy, fp;
    logic [MW-1:0] dist_w;

    function automatic logic [1:0] nxt(input logic [1:0] k);
        nxt = (k == 2'd2) ? 2'd0 : k + 2'd1;
    endfunction

    assign s_cur = (sv_reg == 2'd3) ? 2'd0 : sv_reg;
    assign e_cur = nxt(s_cur);
    assign e_nxt = nxt(e_cur);
    assign dy_c = DW'(yaw_reg[e_cur]) - DW'(yaw_reg[s_cur]);
    assign dp_c = DW'(pitch_reg[e_cur]) - DW'(pitch_reg[s_cur]);
    assign trial = {rem_reg[tpi_pkg::SqW-1:0], sq_reg[tpi_pkg::SqW-1 -: 2]}
                   - {root_reg, 2'b01};
    assign dtrial = {drem_reg[QW-1:0], quo_reg[NW-1]} - {1'b0, den_reg};
    assign sum_w = (NW+1)'(prog_reg) + (NW+1)'(quo_reg);
    assign fin = deg_reg || (sum_w >= (NW+1)'(1 << tpi_pkg::FracBits));
    assign fy = py_reg >>> tpi_pkg::FracBits;
    assign fp = pp_reg >>> tpi_pkg::FracBits;
    assign dist_w = MW'(speed_reg) * MW'(time_reg);

    assign status.len_zero = (root_reg == '0);
    assign status.done_cnt = (cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= tpi_pkg::SpeedW'(tpi_pkg::SpeedReset);
            for (int i = 0; i < 3; i++)
            begin
                yaw_reg[i] <= '0;
                pitch_reg[i] <= '0;
            end
            sv_reg <= '0;
            prog_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    tpi_pkg::RegSpeed:  speed_reg <= cfg_data;
                    tpi_pkg::RegYaw0:   yaw_reg[0] <= cfg_data[CW-1:0];
                    tpi_pkg::RegPitch0: pitch_reg[0] <= cfg_data[CW-1:0];
                    tpi_pkg::RegYaw1:   yaw_reg[1] <= cfg_data[CW-1:0];
                    tpi_pkg::RegPitch1: pitch_reg[1] <= cfg_data[CW-1:0];
                    tpi_pkg::RegYaw2:   yaw_reg[2] <= cfg_data[CW-1:0];
                    tpi_pkg::RegPitch2: pitch_reg[2] <= cfg_data[CW-1:0];
                    default: ;
                endcase
            end
            if (cmd.advance)
            begin
                if (fin)
                begin
                    prog_reg <= '0;
                    sv_reg <= e_cur;
                end
                else
                begin
                    prog_reg <= PW'(sum_w);
                    sv_reg <= s_cur;
                end
            end
            if (cmd.out_load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            time_reg <= time_in;
            dy_reg <= dy_c;
            dp_reg <= dp_c;
        end
        if (cmd.sq_step)
        begin
            sq_reg <= tpi_pkg::SqW'(dy_reg * dy_reg) + tpi_pkg::SqW'(dp_reg * dp_reg);
        end
        if (cmd.sqrt_init)
        begin
            rem_reg <= '0;
            root_reg <= '0;
            cnt_reg <= tpi_pkg::CntW'(tpi_pkg::SqW / 2 - 1);
        end
        if (cmd.sqrt_step)
        begin
            sq_reg <= {sq_reg[tpi_pkg::SqW-3:0], 2'b00};
            cnt_reg <= cnt_reg - 1'b1;
            if (!trial[tpi_pkg::SqW+1])
            begin
                rem_reg <= trial;
                root_reg <= {root_reg[tpi_pkg::LenW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[tpi_pkg::SqW-1:0], sq_reg[tpi_pkg::SqW-1 -: 2]};
                root_reg <= {root_reg[tpi_pkg::LenW-2:0], 1'b0};
            end
        end
        if (cmd.div_init)
        begin
            quo_reg <= {dist_w, {tpi_pkg::FracBits{1'b0}}};
            den_reg <= {root_reg, 16'd0};
            drem_reg <= '0;
            cnt_reg <= tpi_pkg::CntW'(NW - 1);
        end
        if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (!dtrial[QW])
            begin
                drem_reg <= dtrial;
                quo_reg <= {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= {drem_reg[QW-1:0], quo_reg[NW-1]};
                quo_reg <= {quo_reg[NW-2:0], 1'b0};
            end
        end
        if (cmd.sqrt_init)
        begin
            quo_reg <= '0;
            deg_reg <= 1'b0;
        end
        if (cmd.div_step == 1'b0 && cmd.sqrt_step == 1'b0 && cmd.sq_step == 1'b0
            && status.len_zero && !cmd.sqrt_init && !cmd.load && !cmd.div_init
            && !cmd.advance && !cmd.interp_a && !cmd.interp_b && !cmd.out_load)
        begin
            deg_reg <= 1'b1;
        end
        if (cmd.advance)
        begin
            sw_reg <= fin;
            if (fin)
            begin
                dy_reg <= DW'(yaw_reg[e_nxt]) - DW'(yaw_reg[e_cur]);
                dp_reg <= DW'(pitch_reg[e_nxt]) - DW'(pitch_reg[e_cur]);
            end
        end
        if (cmd.interp_a)
        begin
            py_reg <= dy_reg * $signed({1'b0, prog_reg});
            pp_reg <= dp_reg * $signed({1'b0, prog_reg});
        end
        if (cmd.interp_b)
        begin
            ty_reg <= CW'(yaw_reg[sv_reg] + CW'(fy));
            tp_reg <= CW'(pitch_reg[sv_reg] + CW'(fp));
        end
        if (cmd.out_load)
        begin
            odata_reg <= {1'b0, deg_reg, sw_reg, sv_reg,
                          {5{1'b0}}, tp_reg, ty_reg};
        end
    end

    assign out_busy = ovalid_reg && !out_ready;
    assign out_valid = ovalid_reg;
    assign out_data = {odata_reg[39:35], odata_reg[34:30], odata_reg[29:0]};

endmodule

### src/triangle_path_interpolator.sv
// One item at a time: s_tready is high only while idle, and a new item is taken
// only after the last result has been loaded into the output register.
// The bit-serial square root (16 steps) and restoring divider (48 steps) share
// one sequencer; a zero-length edge skips the divider; a stalled output holds it.
// Reset: asynchronous active low; speed 640, vertices 0, progress 0.
// The output register holds a result until taken.
module triangle_path_interpolator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // elapsed_time[15:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // set_yaw[14:0], set_pitch[29:15],
                                   // edge_start[31:30], edge_switched[32],
                                   // degenerate_edge[33], zero fill
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data
);

    tpi_pkg::tpi_cmd_t    cmd;
    tpi_pkg::tpi_status_t status;
    logic                 out_busy;
    logic [39:0]          raw;

    tpi_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (s_tvalid & s_tready),
        .out_busy (out_busy),
        .status   (status),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    tpi_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .time_in   (s_tdata),
        .out_ready (m_tready),
        .status    (status),
        .out_busy  (out_busy),
        .out_valid (m_tvalid),
        .out_data  (raw)
    );

    assign m_tdata = {6'd0, raw[38], raw[37], raw[36:35], raw[29:15], raw[14:0]};

endmodule

### src/tpi_checker.sv
module tpi_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");

    a_deg_sw: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[33] |-> m_tdata[32])
        else $error("degenerate without switch");

    a_start_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:30] != 2'd3)
        else $error("edge start out of range");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted two items back to back");

endmodule

bind triangle_path_interpolator tpi_checker u_tpi_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### bench/tb.sv
`timescale 1ns / 100ps

module tb;

    typedef struct packed {
        logic        degen;
        logic        switched;
        logic [1:0]  start;
        logic [14:0] pitch;
        logic [14:0] yaw;
    } setpoint_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [15:0] cfg_data;

    triangle_path_interpolator u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    logic [15:0]  path_speed;
    logic [14:0]  vtx_yaw [3];
    logic [14:0]  vtx_pitch [3];
    logic [1:0]   cur_vertex;
    logic [63:0]  cur_progress;

    setpoint_t    setpoint_q[$];
    int           fail_count;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #100ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic longint sx15(logic [14:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint floor_frac(longint v);
        return v >>> tpi_pkg::FracBits;
    endfunction

    function automatic longint root_floor(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    task automatic predict_setpoint(logic [15:0] dt);
        setpoint_t    sp;
        logic [1:0]   s;
        logic [1:0]   e;
        longint       dy;
        longint       dp;
        longint unsigned len;
        longint unsigned num;
        longint unsigned sum;
        s = (cur_vertex == 2'd3) ? 2'd0 : cur_vertex;
        e = (s == 2'd2) ? 2'd0 : s + 2'd1;
        dy = sx15(vtx_yaw[e]) - sx15(vtx_yaw[s]);
        dp = sx15(vtx_pitch[e]) - sx15(vtx_pitch[s]);
        len = root_floor(dy * dy + dp * dp);
        sp.switched = 1'b0;
        sp.degen = 1'b0;
        if (len == 0)
        begin
            sp.switched = 1'b1;
            sp.degen = 1'b1;
        end
        else
        begin
            num = (longint'(path_speed) * longint'(dt)) << tpi_pkg::FracBits;
            sum = cur_progress + num / (len << 16);
            if (sum >= (64'd1 << tpi_pkg::FracBits))
                sp.switched = 1'b1;
            else
                cur_progress = sum;
        end
        if (sp.switched)
        begin
            cur_progress = 0;
            s = e;
            e = (s == 2'd2) ? 2'd0 : s + 2'd1;
        end
        cur_vertex = s;
        dy = sx15(vtx_yaw[e]) - sx15(vtx_yaw[s]);
        dp = sx15(vtx_pitch[e]) - sx15(vtx_pitch[s]);
        sp.yaw = 15'(sx15(vtx_yaw[s]) + floor_frac(dy * longint'(cur_progress)));
        sp.pitch = 15'(sx15(vtx_pitch[s]) + floor_frac(dp * longint'(cur_progress)));
        sp.start = s;
        setpoint_q.push_back(sp);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        case (idx)
            tpi_pkg::RegSpeed:  path_speed   = val;
            tpi_pkg::RegYaw0:   vtx_yaw[0]   = val[14:0];
            tpi_pkg::RegPitch0: vtx_pitch[0] = val[14:0];
            tpi_pkg::RegYaw1:   vtx_yaw[1]   = val[14:0];
            tpi_pkg::RegPitch1: vtx_pitch[1] = val[14:0];
            tpi_pkg::RegYaw2:   vtx_yaw[2]   = val[14:0];
            tpi_pkg::RegPitch2: vtx_pitch[2] = val[14:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_path(logic [15:0] spd, logic [14:0] y0, logic [14:0] p0,
                            logic [14:0] y1, logic [14:0] p1,
                            logic [14:0] y2, logic [14:0] p2);
        write_reg(tpi_pkg::RegSpeed, spd);
        write_reg(tpi_pkg::RegYaw0, {1'b0, y0});
        write_reg(tpi_pkg::RegPitch0, {1'b0, p0});
        write_reg(tpi_pkg::RegYaw1, {1'b0, y1});
        write_reg(tpi_pkg::RegPitch1, {1'b0, p1});
        write_reg(tpi_pkg::RegYaw2, {1'b0, y2});
        write_reg(tpi_pkg::RegPitch2, {1'b0, p2});
    endtask

    task automatic send_tick(logic [15:0] dt);
        while (($urandom_range(99) < send_idle_pct))
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= dt;
        predict_setpoint(dt);
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (setpoint_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_dt();
        case ($urandom_range(5))
            0: return 16'($urandom_range(15));
            1: return 16'hFFFF;
            2: return 16'($urandom_range(65535));
            default: return 16'($urandom_range(4000));
        endcase
    endfunction

    function automatic logic [14:0] rand_coord();
        case ($urandom_range(4))
            0: return 15'h4000;
            1: return 15'h3FFF;
            2: return 15'($urandom_range(200));
            default: return 15'($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        setpoint_t got;
        setpoint_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = setpoint_t'(m_tdata[33:0]);
            if (setpoint_q.size() == 0)
                report_mismatch("unexpected transaction", 0, 0);
            else
            begin
                want = setpoint_q.pop_front();
                if (got.yaw != want.yaw)
                    report_mismatch("set_yaw", sx15(got.yaw), sx15(want.yaw));
                if (got.pitch != want.pitch)
                    report_mismatch("set_pitch", sx15(got.pitch), sx15(want.pitch));
                if (got.start != want.start)
                    report_mismatch("edge_start", got.start, want.start);
                if (got.switched != want.switched)
                    report_mismatch("edge_switched", got.switched, want.switched);
                if (got.degen != want.degen)
                    report_mismatch("degenerate_edge", got.degen, want.degen);
            end
        end
    end

    task automatic test_reset_path;
        send_tick(16'd0);
        send_tick(16'hFFFF);
        send_tick(16'd1);
        drain();
    endtask

    task automatic test_directed;
        set_path(16'd640, 15'd0, 15'd0, 15'd640, 15'd0, 15'd0, 15'd640);
        send_tick(16'd0);
        send_tick(16'd1);
        send_tick(16'h8000);
        send_tick(16'h7FFF);
        send_tick(16'hFFFF);
        send_tick(16'hFFFF);
        drain();
        set_path(16'd0, 15'h4000, 15'h4000, 15'h3FFF, 15'h3FFF, 15'h4000, 15'h3FFF);
        send_tick(16'hFFFF);
        send_tick(16'd100);
        drain();
        set_path(16'hFFFF, 15'h4000, 15'h4000, 15'h3FFF, 15'h3FFF, 15'h4000, 15'h3FFF);
        send_tick(16'd1);
        send_tick(16'd3);
        send_tick(16'hFFFF);
        send_tick(16'd0);
        drain();
        set_path(16'd5, 15'd7, 15'd7, 15'd7, 15'd7, 15'd9, 15'd7);
        send_tick(16'd0);
        send_tick(16'd0);
        send_tick(16'hAAAA);
        send_tick(16'h5555);
        drain();
        write_reg(3'd7, 16'h1234);
        send_tick(16'd200);
        drain();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if (i % 60 == 0)
            begin
                drain();
                set_path(($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3000)),
                         rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord(), rand_coord());
            end
            send_tick(rand_dt());
        end
        drain();
    endtask

    task automatic test_backpressure;
        hold_cycles = 600;
        for (int i = 0; i < 12; i++)
            send_tick(rand_dt());
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        fail_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        path_speed = 16'(tpi_pkg::SpeedReset);
        for (int k = 0; k < 3; k++)
        begin
            vtx_yaw[k] = '0;
            vtx_pitch[k] = '0;
        end
        cur_vertex = '0;
        cur_progress = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_path();
        test_directed();
        test_random(480);
        send_idle_pct = 86;
        test_random(480);
        send_idle_pct = 0;
        recv_stall_pct = 86;
        test_random(480);
        send_idle_pct = 38;
        recv_stall_pct = 38;
        test_random(480);
        recv_stall_pct = 0;
        send_idle_pct = 0;
        test_backpressure();

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
